// ----- src/assert_macros.svh -----
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- src/lvbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lvbp_pkg
// Shared types and constants of the label/value block parser.
// ----------------------------------------------------------------------------
package lvbp_pkg;

    localparam int LineCapacity = 64;
    localparam int QueueDepth   = 4;

    // Result status codes.
    localparam logic [1:0] ST_BUSY       = 2'd0;
    localparam logic [1:0] ST_VALID      = 2'd1;
    localparam logic [1:0] ST_BAD_SUM    = 2'd2;
    localparam logic [1:0] ST_INCOMPLETE = 2'd3;

    // Classified byte kinds handed from the front to the back.
    typedef enum logic [2:0] {
        K_BLOCK_END,
        K_CR,
        K_NEWLINE,
        K_KEEP,
        K_OVERLONG,
        K_BAD
    } kind_t;

    // One classified byte.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } item_t;

    localparam int ItemW = $bits(item_t);

    // One result transaction.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] vbat;
        logic [31:0] vpanel;
        logic [31:0] ibat;
        logic [31:0] panel_w;
        logic [31:0] blocks_received;
        logic [31:0] blocks_valid;
        logic [31:0] blocks_bad_sum;
        logic [31:0] blocks_incomplete;
    } result_t;

endpackage

// ----- src/label_value_block_parser.sv -----
// ----------------------------------------------------------------------------
// label_value_block_parser
// Byte-stream parser for label TAB value blocks closed by a checksum line.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per transaction in tdata.
//   m_axis returns exactly one result per byte: status, the four values of a
//   valid block (zero otherwise) and the four wrapping block counters.
//   A classifier stage tracks line length and the checksum label; a
//   four-entry queue decouples it from the back end, which matches labels,
//   accumulates decimals and judges blocks. One byte per cycle is sustained
//   while m_axis_tready stays high; a result passes through the classifier register, the queue and the result register.
//   A stalled m_axis fills the result register, then the queue and the
//   classifier register, then s_axis_tready drops; nothing is lost.
//   Reset clears all parser state, pending values and counters.
// ----------------------------------------------------------------------------
module label_value_block_parser #(
    parameter int LINE_CAPACITY = lvbp_pkg::LineCapacity
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // rx_byte[7:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [263:0] m_axis_tdata    // status, vbat, vpanel, ibat,
                                         // panel_w, blocks_received, blocks_valid,
                                         // blocks_bad_sum, blocks_incomplete, zero pad
);
    import lvbp_pkg::*;

    logic    f_valid, f_ready, q_valid, q_ready;
    item_t   f_item, q_item;
    logic [ItemW-1:0] q_data;
    result_t res;

    lvbp_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_byte(s_axis_tdata),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    lvbp_queue #(.DEPTH(QueueDepth), .WIDTH(ItemW)) u_queue (
        .clk, .rst_n,
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    assign q_item = item_t'(q_data);

    lvbp_back u_back (
        .clk, .rst_n,
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    // Pack the result, first field in the lowest bits.
    assign m_axis_tdata = {6'd0, res.blocks_incomplete, res.blocks_bad_sum,
                           res.blocks_valid, res.blocks_received, res.panel_w,
                           res.ibat, res.vpanel, res.vbat, res.status};
endmodule

// ----- src/lvbp_front.sv -----
// ----------------------------------------------------------------------------
// lvbp_front
// Classifies each received byte; tracks the line length and checksum line.
// ----------------------------------------------------------------------------
module lvbp_front #(
    parameter int LINE_CAPACITY = lvbp_pkg::LineCapacity
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output lvbp_pkg::item_t     out_item
);
    import lvbp_pkg::*;

    localparam int CntW = $clog2(LINE_CAPACITY);

    typedef enum logic [3:0] {
        L_EMPTY, L_C1, L_C2, L_C3, L_C4, L_C5, L_C6, L_C7, L_C8, L_OTHER
    } ck_t;

    logic [CntW-1:0] count_reg, count_next;
    logic            tab_reg, tab_next;
    ck_t             ck_reg, ck_next;
    logic            fire;
    kind_t           kind;
    logic [7:0]      ck_char;

    assign in_ready  = !out_valid || out_ready;
    assign fire      = in_valid && in_ready;

    // Expected next character of the checksum label.
    always_comb
    begin
        case (ck_reg)
            L_EMPTY: ck_char = "C";
            L_C1:    ck_char = "h";
            L_C2:    ck_char = "e";
            L_C3:    ck_char = "c";
            L_C4:    ck_char = "k";
            L_C5:    ck_char = "s";
            L_C6:    ck_char = "u";
            L_C7:    ck_char = "m";
            default: ck_char = 8'd0;
        endcase
    end

    // Byte classification and line tracking.
    always_comb
    begin
        count_next = count_reg;
        tab_next   = tab_reg;
        ck_next    = ck_reg;
        if (tab_reg && ck_reg == L_C8 && 32'(count_reg) == 32'd9) begin
            kind = K_BLOCK_END;
            count_next = '0;
            tab_next = 1'b0;
            ck_next = L_EMPTY;
        end else if (in_byte == 8'h0d) begin
            kind = K_CR;
        end else if (in_byte == 8'h0a) begin
            kind = K_NEWLINE;
            count_next = '0;
            tab_next = 1'b0;
            ck_next = L_EMPTY;
        end else if ((in_byte >= 8'd32 && in_byte <= 8'd126) || in_byte == 8'h09) begin
            if (32'(count_reg) < LINE_CAPACITY - 1) begin
                kind = K_KEEP;
                count_next = count_reg + 1'b1;
                if (!tab_reg) begin
                    if (in_byte == 8'h09) tab_next = 1'b1;
                    else if (ck_reg != L_OTHER && ck_reg != L_C8 && in_byte == ck_char)
                        ck_next = ck_t'(ck_reg + 4'd1);
                    else ck_next = L_OTHER;
                end
            end else begin
                kind = K_OVERLONG;
            end
        end else begin
            kind = K_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            tab_reg   <= 1'b0;
            ck_reg    <= L_EMPTY;
            out_valid <= 1'b0;
        end else begin
            if (fire) begin
                count_reg <= count_next;
                tab_reg   <= tab_next;
                ck_reg    <= ck_next;
            end
            if (fire) out_valid <= 1'b1;
            else if (out_ready) out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            out_item.kind <= kind;
            out_item.data <= in_byte;
        end
    end

`include "assert_macros.svh"
    `ASSERT_IMPL(a_count_cap, clk, rst_n, 1'b1, 32'(count_reg) < LINE_CAPACITY)
    `ASSERT_NEXT(a_end_clears, clk, rst_n, fire && kind == K_BLOCK_END, count_reg == '0)
    `ASSERT_IMPL(a_c8_tab, clk, rst_n, ck_reg == L_C8 && tab_reg, 32'(count_reg) >= 32'd9)
endmodule

// ----- src/lvbp_queue.sv -----
// ----------------------------------------------------------------------------
// lvbp_queue
// Short FIFO between the classifier and the executing back end.
// ----------------------------------------------------------------------------
module lvbp_queue #(
    parameter int DEPTH = lvbp_pkg::QueueDepth,
    parameter int WIDTH = lvbp_pkg::ItemW
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PtrW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PtrW-1:0]  wr_reg, rd_reg;
    logic [PtrW:0]    cnt_reg;
    logic             push, pop;

    assign in_ready  = cnt_reg != (PtrW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push) mem[wr_reg] <= in_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (32'(wr_reg) == DEPTH - 1) ? '0 : wr_reg + 1'b1;
            if (pop)  rd_reg <= (32'(rd_reg) == DEPTH - 1) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end
endmodule

// ----- src/lvbp_back.sv -----
// ----------------------------------------------------------------------------
// lvbp_back
// Executes classified bytes: label match, decimal value, block judgement.
// ----------------------------------------------------------------------------
module lvbp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lvbp_pkg::item_t     in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output lvbp_pkg::result_t   out_res
);
    import lvbp_pkg::*;

    typedef enum logic [3:0] {
        T_EMPTY, T_V, T_VP, T_VPV, T_I, T_P, T_PP, T_PPV, T_NONE
    } lab_t;

    logic [7:0]  sum_reg, sum_next;
    logic        bad_reg, bad_next;
    logic [3:0]  seen_reg, seen_next;
    logic        tab_reg, tab_next;
    lab_t        lab_reg, lab_next;
    logic [1:0]  ph_reg, ph_next;
    logic        neg_reg, neg_next;
    logic [31:0] mag_reg, mag_next;
    logic        inv_reg, inv_next;
    logic        len_reg, len_next;
    logic [31:0] pend_reg [4];
    logic [31:0] pend_next [4];
    logic [31:0] ctr_reg [4];
    logic [31:0] ctr_next [4];
    result_t     res;
    logic        fire;
    logic [7:0]  c;
    logic [35:0] mag10;
    logic        ok;
    logic [1:0]  slot;
    logic        known;

    assign in_ready = !out_valid || out_ready;
    assign fire     = in_valid && in_ready;
    assign c        = in_item.data;
    assign mag10    = {4'd0, mag_reg} * 36'd10 + 36'(c - 8'd48);

    always_comb
    begin
        sum_next = sum_reg + c;
        bad_next = bad_reg; seen_next = seen_reg; tab_next = tab_reg;
        lab_next = lab_reg; ph_next = ph_reg; neg_next = neg_reg;
        mag_next = mag_reg; inv_next = inv_reg; len_next = len_reg;
        pend_next = pend_reg; ctr_next = ctr_reg;
        res = '0;
        ok = 1'b0; slot = 2'd0; known = 1'b0;
        res.status = ST_BUSY;
        case (in_item.kind)
            K_BLOCK_END:
            begin
                ctr_next[0] = ctr_reg[0] + 32'd1;
                if (sum_next != 8'd0) begin
                    ctr_next[2] = ctr_reg[2] + 32'd1;
                    res.status = ST_BAD_SUM;
                end else if (bad_reg || seen_reg != 4'hf) begin
                    ctr_next[3] = ctr_reg[3] + 32'd1;
                    res.status = ST_INCOMPLETE;
                end else begin
                    ctr_next[1] = ctr_reg[1] + 32'd1;
                    res.status = ST_VALID;
                    res.vbat = pend_reg[0];
                    res.vpanel = pend_reg[1];
                    res.ibat = pend_reg[2];
                    res.panel_w = pend_reg[3];
                end
                for (int i = 0; i < 4; i++) pend_next[i] = '0;
                sum_next = '0; seen_next = '0; bad_next = 1'b0;
                tab_next = 1'b0; lab_next = T_EMPTY; ph_next = '0;
                neg_next = 1'b0; mag_next = '0; inv_next = 1'b0; len_next = 1'b0;
            end
            K_CR: ;
            K_NEWLINE:
            begin
                if (len_reg && !bad_reg) begin
                    if (!tab_reg) bad_next = 1'b1;
                    else begin
                        case (lab_reg)
                            T_V:     begin slot = 2'd0; known = 1'b1; end
                            T_VPV:   begin slot = 2'd1; known = 1'b1; end
                            T_I:     begin slot = 2'd2; known = 1'b1; end
                            T_PPV:   begin slot = 2'd3; known = 1'b1; end
                            default: known = 1'b0;
                        endcase
                        ok = ph_reg == 2'd2 && !inv_reg &&
                             (neg_reg ? mag_reg <= 32'h8000_0000 : mag_reg <= 32'h7fff_ffff);
                        if (known) begin
                            if (!ok) bad_next = 1'b1;
                            else begin
                                pend_next[slot] = neg_reg ? 32'd0 - mag_reg : mag_reg;
                                seen_next[slot] = 1'b1;
                            end
                        end
                    end
                end
                tab_next = 1'b0; lab_next = T_EMPTY; ph_next = '0;
                neg_next = 1'b0; mag_next = '0; inv_next = 1'b0; len_next = 1'b0;
            end
            K_KEEP:
            begin
                len_next = 1'b1;
                if (tab_reg) begin
                    if (inv_reg) ;
                    else if (ph_reg == 2'd0 && (c == 8'd32 || c == 8'h09)) ;
                    else if (ph_reg == 2'd0 && (c == "+" || c == "-")) begin
                        neg_next = c == "-";
                        ph_next = 2'd1;
                    end else if (!(c >= "0" && c <= "9")) inv_next = 1'b1;
                    else begin
                        ph_next = 2'd2;
                        if (mag_reg > 32'd214748364) inv_next = 1'b1;
                        else begin
                            mag_next = mag10[31:0];
                            if (mag10 > 36'h0_8000_0000) inv_next = 1'b1;
                        end
                    end
                end else if (c == 8'h09) tab_next = 1'b1;
                else begin
                    case (lab_reg)
                        T_EMPTY: lab_next = c == "V" ? T_V : c == "I" ? T_I :
                                            c == "P" ? T_P : T_NONE;
                        T_V:     lab_next = c == "P" ? T_VP : T_NONE;
                        T_VP:    lab_next = c == "V" ? T_VPV : T_NONE;
                        T_P:     lab_next = c == "P" ? T_PP : T_NONE;
                        T_PP:    lab_next = c == "V" ? T_PPV : T_NONE;
                        default: lab_next = T_NONE;
                    endcase
                end
            end
            default: bad_next = 1'b1;
        endcase
        res.blocks_received = ctr_next[0];
        res.blocks_valid = ctr_next[1];
        res.blocks_bad_sum = ctr_next[2];
        res.blocks_incomplete = ctr_next[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sum_reg <= '0; bad_reg <= 1'b0; seen_reg <= '0; tab_reg <= 1'b0;
            lab_reg <= T_EMPTY; ph_reg <= '0; neg_reg <= 1'b0; mag_reg <= '0;
            inv_reg <= 1'b0; len_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                pend_reg[i] <= '0;
                ctr_reg[i] <= '0;
            end
            out_valid <= 1'b0;
        end else begin
            if (fire) begin
                sum_reg <= sum_next; tab_reg <= tab_next; lab_reg <= lab_next;
                ph_reg <= ph_next; neg_reg <= neg_next; mag_reg <= mag_next;
                inv_reg <= inv_next; len_reg <= len_next;
                ctr_reg <= ctr_next;
                bad_reg <= bad_next; seen_reg <= seen_next; pend_reg <= pend_next;
            end
            if (fire) out_valid <= 1'b1;
            else if (out_ready) out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) out_res <= res;
    end

`include "assert_macros.svh"
    `ASSERT_IMPL(a_valid_all, clk, rst_n, fire && res.status == ST_VALID, seen_reg == 4'hf)
    `ASSERT_NEXT(a_end_sum, clk, rst_n, fire && in_item.kind == K_BLOCK_END, sum_reg == 8'd0)
    `ASSERT_IMPL(a_end_count, clk, rst_n, fire && in_item.kind == K_BLOCK_END, res.blocks_received == ctr_reg[0] + 32'd1)
endmodule
